[rtl/core/pfc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// pfc_pkg: shared types and constants for the predicate filter
// Operation codes, register indexes, float compare helpers, queue word type.
// -----------------------------------------------------------------------------
package pfc_pkg;

	localparam int INPUT_LANES = 4;
	localparam int CNT_W       = 32;
	localparam int FP_W        = 32;

	// predicate operation codes
	localparam logic [2:0] OP_EQ  = 3'd0;
	localparam logic [2:0] OP_NE  = 3'd1;
	localparam logic [2:0] OP_LT  = 3'd2;
	localparam logic [2:0] OP_LE  = 3'd3;
	localparam logic [2:0] OP_GT  = 3'd4;
	localparam logic [2:0] OP_GE  = 3'd5;
	localparam logic [2:0] OP_IN  = 3'd6;
	localparam logic [2:0] OP_NIN = 3'd7;

	// register indexes
	localparam logic [2:0] REG_PRED_COUNT = 3'd0;
	localparam logic [2:0] REG_PRED_OPS   = 3'd1;
	localparam logic [2:0] REG_LIMIT_01   = 3'd2;
	localparam logic [2:0] REG_LIMIT_23   = 3'd3;
	localparam logic [2:0] REG_SET_0      = 3'd4;
	localparam logic [2:0] REG_SET_1      = 3'd5;
	localparam logic [2:0] REG_SET_2      = 3'd6;
	localparam logic [2:0] REG_SET_3      = 3'd7;

	// classified point passed from front to back
	typedef struct packed {
		logic pass;
		logic last;
	} pfc_cls_t;

	// result word
	typedef struct packed {
		logic [CNT_W-1:0] kept_count;
		logic             end_of_cloud;
		logic             passed;
		logic [CNT_W-1:0] point_index;
	} pfc_res_t;

	function automatic logic fp_is_nan(input logic [FP_W-1:0] a);
		return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
	endfunction

	// IEEE equality: NaN never equal, -0 == +0
	function automatic logic fp_eq(input logic [FP_W-1:0] a, input logic [FP_W-1:0] b);
		if (fp_is_nan(a) || fp_is_nan(b))
			return 1'b0;
		return (a == b) || ((a[30:0] == 31'd0) && (b[30:0] == 31'd0));
	endfunction

	// IEEE less-than, false on NaN
	function automatic logic fp_lt(input logic [FP_W-1:0] a, input logic [FP_W-1:0] b);
		if (fp_is_nan(a) || fp_is_nan(b))
			return 1'b0;
		if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0))
			return 1'b0;
		if (a[31] != b[31])
			return a[31];
		if (a[31])
			return a[30:0] > b[30:0];
		return a[30:0] < b[30:0];
	endfunction

endpackage
`default_nettype wire

[rtl/core/pfc_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// pfc_front: predicate evaluation
// Evaluates all enabled lanes of one point in parallel, registered result.
// -----------------------------------------------------------------------------
module pfc_front #(
	parameter int NUM_PREDICATES = 4,
	parameter int SET_SLOTS      = 2
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    in_valid,
	output logic                   in_ready,
	input  wire  [127:0]           in_values,
	input  wire                    in_last,
	input  wire  [2:0]             pred_count,
	input  wire  [11:0]            pred_ops,
	input  wire  [63:0]            limit_01,
	input  wire  [63:0]            limit_23,
	input  wire  [255:0]           set_pairs,
	output logic                   cls_valid,
	input  wire                    cls_ready,
	output pfc_pkg::pfc_cls_t      cls
);
	import pfc_pkg::*;

	localparam int CAP = (NUM_PREDICATES < INPUT_LANES) ? NUM_PREDICATES : INPUT_LANES;

	logic [2:0] lanes;
	logic       pass;
	logic       valid_s1;
	pfc_cls_t   cls_s1;

	// per-lane compare, all lanes in parallel
	always_comb begin
		logic [FP_W-1:0] v, lim, m;
		logic [2:0]      op;
		logic            hit, hold;
		lanes = (pred_count > 3'(CAP)) ? 3'(CAP) : pred_count;
		pass  = 1'b1;
		for (int i = 0; i < INPUT_LANES; i++) begin
			v   = in_values[i*FP_W +: FP_W];
			lim = (i < 2) ? limit_01[(i%2)*FP_W +: FP_W] : limit_23[(i%2)*FP_W +: FP_W];
			op  = pred_ops[i*3 +: 3];
			hit = 1'b0;
			for (int k = 0; k < SET_SLOTS; k++) begin
				m   = set_pairs[i*64 + (k%2)*FP_W +: FP_W];
				hit = hit | fp_eq(v, m);
			end
			case (op)
				OP_EQ:   hold = fp_eq(v, lim);
				OP_NE:   hold = !fp_eq(v, lim);
				OP_LT:   hold = fp_lt(v, lim);
				OP_LE:   hold = fp_lt(v, lim) || fp_eq(v, lim);
				OP_GT:   hold = fp_lt(lim, v);
				OP_GE:   hold = fp_lt(lim, v) || fp_eq(v, lim);
				OP_IN:   hold = hit;
				OP_NIN:  hold = !hit;
				default: hold = 1'b0;
			endcase
			if ((3'(i) < lanes) && !hold)
				pass = 1'b0;
		end
	end

	assign in_ready  = !valid_s1 || cls_ready;
	assign cls_valid = valid_s1;
	assign cls       = cls_s1;

	// stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cls_s1.pass <= pass;
			cls_s1.last <= in_last;
		end
	end

endmodule
`default_nettype wire

[rtl/core/pfc_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// pfc_queue: two-entry queue between front and back
// Decouples the two sides so either may stall alone.
// -----------------------------------------------------------------------------
module pfc_queue (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                wr_valid,
	output logic               wr_ready,
	input  pfc_pkg::pfc_cls_t  wr_data,
	output logic               rd_valid,
	input  wire                rd_ready,
	output pfc_pkg::pfc_cls_t  rd_data
);
	import pfc_pkg::*;

	pfc_cls_t   mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       wr, rd;

	assign wr_ready = cnt_q != 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign rd_data  = mem_q[rp_q];
	assign wr       = wr_valid && wr_ready;
	assign rd       = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) wp_q <= !wp_q;
			if (rd) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(wr) - 2'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end

endmodule
`default_nettype wire

[rtl/core/pfc_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// pfc_back: counters and result compaction
// Updates point and kept counters and emits results into an output register.
// -----------------------------------------------------------------------------
module pfc_back (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                cls_valid,
	output logic               cls_ready,
	input  pfc_pkg::pfc_cls_t  cls,
	output logic               res_valid,
	input  wire                res_ready,
	output pfc_pkg::pfc_res_t  res
);
	import pfc_pkg::*;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	logic [CNT_W-1:0] point_q, kept_q, kept_nx;
	logic             res_valid_q;
	pfc_res_t         res_q;
	logic             take, emit;

	assign cls_ready = !res_valid_q || res_ready;
	assign take      = cls_valid && cls_ready;
	assign emit      = cls.pass || cls.last;
	assign kept_nx   = (cls.pass && kept_q != CNT_MAX) ? kept_q + 1'b1 : kept_q;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// counters and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_q     <= '0;
			kept_q      <= '0;
			res_valid_q <= 1'b0;
		end else if (cls_ready) begin
			res_valid_q <= take && emit;
			if (take) begin
				if (cls.last) begin
					point_q <= '0;
					kept_q  <= '0;
				end else begin
					kept_q <= kept_nx;
					if (point_q != CNT_MAX) point_q <= point_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q.point_index  <= point_q;
			res_q.passed       <= cls.pass;
			res_q.end_of_cloud <= cls.last;
			res_q.kept_count   <= kept_nx;
		end
	end

endmodule
`default_nettype wire

[rtl/core/predicate_filter_compaction_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// predicate_filter_compaction_top: float predicate filter with compaction
// Filters float32 points against up to four predicates and emits indexes.
// -----------------------------------------------------------------------------
// One point per cycle sustained while the output is not stalled. A point is
// evaluated in one registered stage (all lanes in parallel), passes through
// a two-entry queue and reaches the counter stage, which drives a registered
// result word. Failing points that are not last produce no result. Write
// configuration only while idle.
module predicate_filter_compaction_top #(
	parameter int NUM_PREDICATES = 4,
	parameter int SET_SLOTS      = 2
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_axis_tvalid,
	output logic         s_axis_tready,
	input  wire  [127:0] s_axis_tdata,   // value_0, value_1, value_2, value_3
	input  wire          s_axis_tlast,   // last_point
	output logic         m_axis_tvalid,
	input  wire          m_axis_tready,
	output logic [71:0]  m_axis_tdata,   // point_index, passed, end_of_cloud, kept_count, pad
	input  wire          cfg_valid,
	output logic         cfg_ready,
	input  wire  [2:0]   cfg_index,
	input  wire  [63:0]  cfg_data
);
	import pfc_pkg::*;

	logic [2:0]   pred_count_q;
	logic [11:0]  pred_ops_q;
	logic [63:0]  limit_01_q, limit_23_q;
	logic [255:0] set_pairs_q;
	logic         f_valid, f_ready, q_valid, q_ready;
	pfc_cls_t     f_cls, q_cls;
	pfc_res_t     res;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pred_count_q <= '0;
			pred_ops_q   <= '0;
			limit_01_q   <= '0;
			limit_23_q   <= '0;
			set_pairs_q  <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_PRED_COUNT: pred_count_q <= cfg_data[2:0];
				REG_PRED_OPS:   pred_ops_q   <= cfg_data[11:0];
				REG_LIMIT_01:   limit_01_q   <= cfg_data;
				REG_LIMIT_23:   limit_23_q   <= cfg_data;
				REG_SET_0:      set_pairs_q[63:0]    <= cfg_data;
				REG_SET_1:      set_pairs_q[127:64]  <= cfg_data;
				REG_SET_2:      set_pairs_q[191:128] <= cfg_data;
				REG_SET_3:      set_pairs_q[255:192] <= cfg_data;
				default: ;
			endcase
		end
	end

	pfc_front #(.NUM_PREDICATES(NUM_PREDICATES), .SET_SLOTS(SET_SLOTS)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_values(s_axis_tdata), .in_last(s_axis_tlast),
		.pred_count(pred_count_q), .pred_ops(pred_ops_q),
		.limit_01(limit_01_q), .limit_23(limit_23_q), .set_pairs(set_pairs_q),
		.cls_valid(f_valid), .cls_ready(f_ready), .cls(f_cls)
	);

	pfc_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_cls),
		.rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_cls)
	);

	pfc_back u_back (
		.clk(clk), .arst_n(arst_n),
		.cls_valid(q_valid), .cls_ready(q_ready), .cls(q_cls),
		.res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res(res)
	);

	assign m_axis_tdata = {6'd0, res.kept_count, res.end_of_cloud, res.passed,
		res.point_index};

	// output word holds while stalled
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed under stall");
	// a result that did not pass must be end of cloud
	a_fail_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !res.passed |-> res.end_of_cloud)
		else $error("failing result without end of cloud");
	// kept count never exceeds index plus one
	a_kept: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && res.point_index != 32'hFFFFFFFF |->
		res.kept_count <= res.point_index + 32'd1)
		else $error("kept count too large");

endmodule
`default_nettype wire
